[src/lap_pkg.sv]
// ---------------------------------------------------------------------------
// lap_pkg
// Shared constants and types for the 4-neighbour Laplacian edge filter.
// ---------------------------------------------------------------------------
package lap_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int IDX_W  = 1;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

    typedef struct packed {
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic [PIX_W-1:0] out_value;
        logic             last_of_run;
    } t_res;

endpackage

[src/lap_if.sv]
// ---------------------------------------------------------------------------
// lap_pix_if / lap_res_if
// Valid/ready channels for input pixels and filtered results.
// ---------------------------------------------------------------------------
interface lap_pix_if import lap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lap_res_if import lap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic [PIX_W-1:0] out_value;
    logic             last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last_of_run, output ready);
endinterface

[src/lap_outq.sv]
// ---------------------------------------------------------------------------
// lap_outq
// Four-entry result queue: takes up to two results a cycle, sends one while the sink is ready.
// ---------------------------------------------------------------------------
module lap_outq import lap_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push_n,
    input  t_res           i_rec0,
    input  t_res           i_rec1,
    output logic           o_space,
    lap_res_if.source      o_res
);

    t_res       r_q [4];
    t_res       n_q [4];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [2:0] base;
    logic       pop;

    assign pop     = o_res.valid && o_res.ready;
    assign o_space = (r_cnt <= 3'd2);

    always_comb begin
        n_q  = r_q;
        base = r_cnt;
        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                n_q[i] = r_q[i+1];
            end
            base = r_cnt - 3'd1;
        end
        if (i_push_n != 2'd0) begin
            n_q[base[1:0]] = i_rec0;
        end
        if (i_push_n == 2'd2) begin
            n_q[base[1:0] + 2'd1] = i_rec1;
        end
        n_cnt = base + {1'b0, i_push_n};
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_res.valid       = (r_cnt != 3'd0);
    assign o_res.out_row     = r_q[0].out_row;
    assign o_res.out_col     = r_q[0].out_col;
    assign o_res.out_value   = r_q[0].out_value;
    assign o_res.last_of_run = r_q[0].last_of_run;

endmodule

[src/laplacian_3x3_edge_filter_top.sv]
// ---------------------------------------------------------------------------
// laplacian_3x3_edge_filter_top
// 4-neighbour 3x3 Laplacian over a raster-order grayscale pixel stream.
// ---------------------------------------------------------------------------
// Takes one pixel per clock unless the compute stage is stalled. Both
// previous rows live in one line memory of MAX_WIDTH entries (one read and
// one write port, read registered); each pixel reads its column at transfer
// and writes it back as it leaves the compute stage, which stalls while the
// result queue holds three results or more, with a bypass when consecutive
// pixels hit the same column. A pixel's results pass from the compute stage
// register through a four-entry queue. Pixels that give two results (last
// column of an interior row, columns two and beyond of the last row) outrun
// a one-result-per-cycle output. With a sink always ready, the extra result
// at the end of an interior row is absorbed, while the last row pauses the
// input whenever the queue holds three results; otherwise the rate is one
// pixel per cycle. The line memory needs no clearing after reset.
// ---------------------------------------------------------------------------
module laplacian_3x3_edge_filter_top import lap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    lap_pix_if.sink           i_pix,
    lap_res_if.source         o_res
);

    logic [SIZE_W-1:0] r_img_w, r_img_h;
    logic [SIZE_W-1:0] w_eff, h_eff, wm1, hm1;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd, r_fwd_data, rd, wr_data;
    logic               r_fwd_hit;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_px;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic              r_s1_int, r_s1_bord;

    logic [PIX_W-1:0]  r_w00, r_w10, r_w11, r_w20;

    logic              acc, commit, space;
    logic              is_int, is_bord;
    logic [SIZE_W-1:0] c_ext, r_ext;
    logic [PIX_W-1:0]  top, mid, lap;
    t_res              rec_int, rec_bord, rec0, rec1;
    logic [1:0]        push_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= SIZE_RESET;
            r_img_h <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = SIZE_W'(1);
        end else if (r_img_w > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = SIZE_W'(1);
        end else if (r_img_h > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_img_h;
        end
    end

    assign wm1   = w_eff - SIZE_W'(1);
    assign hm1   = h_eff - SIZE_W'(1);
    assign c_ext = SIZE_W'(r_col);
    assign r_ext = SIZE_W'(r_row);

    assign commit      = r_s1_valid && space;
    assign i_pix.ready = !r_s1_valid || commit;
    assign acc         = i_pix.valid && i_pix.ready;

    assign is_int  = (r_ext >= SIZE_W'(2)) && (c_ext >= SIZE_W'(2)) &&
                     (r_ext < h_eff) && (c_ext < w_eff);
    assign is_bord = (r_row == '0) || (r_col == '0) || (r_ext >= hm1) || (c_ext >= wm1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (c_ext >= wm1) begin
            n_col = '0;
            n_row = (r_ext >= hm1) ? '0 : r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
            if (r_ext > hm1) begin
                n_row = '0;
            end
        end
    end

    assign rd      = r_fwd_hit ? r_fwd_data : r_rd;
    assign top     = rd[2*PIX_W-1:PIX_W];
    assign mid     = rd[PIX_W-1:0];
    assign wr_data = {mid, r_s1_px};

    always_ff @(posedge i_clk) begin
        if (commit) begin
            mem[r_s1_col] <= wr_data;
        end
        if (acc) begin
            r_rd       <= mem[r_col];
            r_fwd_data <= wr_data;
            r_s1_px    <= i_pix.pixel;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_int   <= is_int;
            r_s1_bord  <= is_bord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_w00 <= '0;
            r_w10 <= '0; r_w11 <= '0;
            r_w20 <= '0;
        end else begin
            if (acc) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_fwd_hit <= commit && (r_s1_col == r_col);
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end
            if (commit) begin
                r_w00 <= top;
                r_w11 <= r_w10; r_w10 <= mid;
                r_w20 <= r_s1_px;
            end
        end
    end

    assign lap = {r_w10[PIX_W-3:0], 2'b00} - r_w00 - r_w20 - r_w11 - mid;

    always_comb begin
        rec_int.out_row      = POS_W'(r_s1_row - ROW_W'(1));
        rec_int.out_col      = POS_W'(r_s1_col - COL_W'(1));
        rec_int.out_value    = lap;
        rec_int.last_of_run  = !r_s1_bord;
        rec_bord.out_row     = POS_W'(r_s1_row);
        rec_bord.out_col     = POS_W'(r_s1_col);
        rec_bord.out_value   = r_s1_px;
        rec_bord.last_of_run = 1'b1;
        rec0   = r_s1_int ? rec_int : rec_bord;
        rec1   = rec_bord;
        push_n = commit ? ({1'b0, r_s1_int} + {1'b0, r_s1_bord}) : 2'd0;
    end

    lap_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_rec0   (rec0),
        .i_rec1   (rec1),
        .o_space  (space),
        .o_res    (o_res)
    );

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_valid)
        else $error("transfer did not load the compute stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !commit) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_px)))
        else $error("stalled compute stage lost its pixel");

    a_interior_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_int) |-> (r_s1_row >= ROW_W'(2) && r_s1_col >= COL_W'(2)))
        else $error("interior result at an edge position");

endmodule

[bench/lap_result_checker.sv]
// ---------------------------------------------------------------------------
// lap_result_checker
// Watches the configuration port and both channels of the Laplacian filter,
// predicts every result from the accepted pixels and the sizes in force, and
// compares each result transfer field by field with the oldest prediction.
// Hands the failure count and the number of outstanding predictions to the
// bench top.
// ---------------------------------------------------------------------------
module lap_result_checker import lap_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [SIZE_W-1:0] i_cfg_data,
    lap_pix_if                i_pix,
    lap_res_if                i_res,
    output int                o_fail_count,
    output int                o_pending
);

    logic [PIX_W-1:0]  line_above     [MAX_WIDTH];
    logic [PIX_W-1:0]  line_two_above [MAX_WIDTH];
    // window columns c-1 and c-2; index 0 = row r-2, 1 = row r-1, 2 = row r
    logic [PIX_W-1:0]  win_c1 [3];
    logic [PIX_W-1:0]  win_c2 [3];
    logic [SIZE_W-1:0] width_cfg;
    logic [SIZE_W-1:0] height_cfg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int                fails;
    t_res              expected_q [$];

    function automatic int unsigned active_size(input logic [SIZE_W-1:0] raw,
                                                input int unsigned limit);
        if (raw == '0) return 1;
        if (32'(raw) > limit) return limit;
        return 32'(raw);
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : predict_and_compare
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic [COL_W-1:0] ci;
        logic [PIX_W-1:0] up2;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] px;
        logic [31:0]      acc;
        bit               inner;
        bit               on_border;
        t_res             res;
        t_res             want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH; k++) begin
                line_above[k]     = '0;
                line_two_above[k] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                win_c1[k] = '0;
                win_c2[k] = '0;
            end
            width_cfg  = SIZE_RESET;
            height_cfg = SIZE_RESET;
            col_pos    = 0;
            row_pos    = 0;
            fails      = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    width_cfg = i_cfg_data;
                end else begin
                    height_cfg = i_cfg_data;
                end
            end
            if (i_pix.valid && i_pix.ready) begin
                w   = active_size(width_cfg, MAX_WIDTH);
                h   = active_size(height_cfg, MAX_HEIGHT);
                r   = row_pos;
                c   = col_pos;
                ci  = c[COL_W-1:0];
                px  = i_pix.pixel;
                up2 = '0;
                up1 = '0;
                if (c < MAX_WIDTH) begin
                    up2 = line_two_above[ci];
                    up1 = line_above[ci];
                end
                inner     = (r >= 2 && c >= 2 && r < h && c < w);
                on_border = (r == 0 || c == 0 || r >= h - 1 || c >= w - 1);
                if (inner) begin
                    acc = 32'd4 * 32'(win_c1[1]) - 32'(win_c1[0]) - 32'(win_c1[2])
                        - 32'(win_c2[1]) - 32'(up1);
                    res.out_row     = POS_W'(r - 1);
                    res.out_col     = POS_W'(c - 1);
                    res.out_value   = acc[PIX_W-1:0];
                    res.last_of_run = !on_border;
                    expected_q.push_back(res);
                end
                if (on_border) begin
                    res.out_row     = POS_W'(r);
                    res.out_col     = POS_W'(c);
                    res.out_value   = px;
                    res.last_of_run = 1'b1;
                    expected_q.push_back(res);
                end
                for (int k = 0; k < 3; k++) begin
                    win_c2[k] = win_c1[k];
                end
                win_c1[0] = up2;
                win_c1[1] = up1;
                win_c1[2] = px;
                if (c < MAX_WIDTH) begin
                    line_two_above[ci] = up1;
                    line_above[ci]     = px;
                end
                if (c >= w - 1) begin
                    col_pos = 0;
                    row_pos = (r >= h - 1) ? 0 : r + 1;
                end else begin
                    col_pos = c + 1;
                    if (r > h - 1) row_pos = 0;
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: row %0d col %0d value %0d",
                           i_res.out_row, i_res.out_col, i_res.out_value);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("out_row", 32'(want.out_row), 32'(i_res.out_row));
                    check_field("out_col", 32'(want.out_col), 32'(i_res.out_col));
                    check_field("out_value", 32'(want.out_value), 32'(i_res.out_value));
                    check_field("last_of_run", 32'(want.last_of_run),
                                32'(i_res.last_of_run));
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fails;
    end

endmodule

[bench/laplacian_3x3_edge_filter_top_tb.sv]
// ---------------------------------------------------------------------------
// laplacian_3x3_edge_filter_top_tb
// Stimulus and verdict for the 4-neighbour Laplacian edge filter.
// ---------------------------------------------------------------------------
// Streams small checkerboard and tiny images, the widest row and part of a
// clamped tall column, then random frames and mid-image size changes with
// random pixel content. Both channels idle at random. Sizes are rewritten only
// once the checker has seen every predicted result; the checker does all
// comparison.
// ---------------------------------------------------------------------------
module laplacian_3x3_edge_filter_top_tb;
    import lap_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 560;
    localparam int SETTLE_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_idx;
    logic [SIZE_W-1:0] cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                random_sent;
    bit                src_steady;
    bit                sink_steady;

    lap_pix_if pix_if ();
    lap_res_if res_if ();

    laplacian_3x3_edge_filter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    lap_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int dim_of(input logic [SIZE_W-1:0] raw, input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return '0;
        if (roll < 5) return SIZE_W'($urandom_range(1, 2));
        if (roll < 17) return SIZE_W'($urandom_range(3, 10));
        return SIZE_W'($urandom_range(11, 24));
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] value);
        int gap;
        gap = (!src_steady && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.pixel <= value;
        @(negedge clk);
        while (!pix_if.ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic stream(input int count, input bit harsh);
        for (int k = 0; k < count; k++) begin
            if (harsh && $urandom_range(0, 3) != 0) begin
                push_pixel(($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00);
            end else begin
                push_pixel(PIX_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // hold off until every predicted result has been seen, then let the pipe empty
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_geometry(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_IMAGE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx  <= REG_IMAGE_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin : sink_side
        int hold;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else begin
                res_if.ready <= 1'b1;
                if (!sink_steady && $urandom_range(0, 2) == 0) hold = idle_len();
            end
        end
    end

    initial begin : stimulus
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        int                w_eff;
        int                h_eff;
        int                n;
        int                extra;
        bit                harsh;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_IMAGE_WIDTH;
        cfg_data     <= '0;
        pix_if.valid <= 1'b0;
        pix_if.pixel <= '0;
        src_steady   = 1'b0;
        sink_steady  = 1'b0;
        random_sent  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // checkerboard drives both extremes of the sum
        set_geometry(SIZE_W'(4), SIZE_W'(4));
        for (int k = 0; k < 16; k++) begin
            push_pixel(((k / 4 + k % 4) % 2 == 1) ? 8'hFF : 8'h00);
        end
        settle();
        set_geometry(SIZE_W'(2), SIZE_W'(3));
        stream(6, 1'b0);
        settle();
        set_geometry('0, '0);
        push_pixel(8'hA5);
        settle();

        set_geometry(11'h7FF, SIZE_W'(1));
        stream(MAX_WIDTH, 1'b0);
        settle();
        // clamped height: run part way down, then realign with a 1x1 pixel
        set_geometry(SIZE_W'(1), 11'h7FF);
        stream(64, 1'b0);
        settle();
        set_geometry(SIZE_W'(1), SIZE_W'(1));
        stream(1, 1'b0);
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            harsh       = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) < 8) begin
                w_raw = pick_dim();
                h_raw = pick_dim();
                if (dim_of(w_raw, MAX_WIDTH) * dim_of(h_raw, MAX_HEIGHT) > 240) begin
                    h_raw = SIZE_W'(3);
                end
                n = dim_of(w_raw, MAX_WIDTH) * dim_of(h_raw, MAX_HEIGHT)
                  * $urandom_range(1, 2);
                set_geometry(w_raw, h_raw);
                stream(n, harsh);
                settle();
                random_sent += n;
            end else begin
                // narrow or resize once two full rows are in, then realign with a 1x1 pixel
                w_eff = $urandom_range(3, 12);
                h_eff = $urandom_range(3, 8);
                set_geometry(SIZE_W'(w_eff), SIZE_W'(h_eff));
                n = $urandom_range(2 * w_eff, w_eff * h_eff - 1);
                stream(n, harsh);
                settle();
                set_geometry(SIZE_W'($urandom_range(0, w_eff)), SIZE_W'($urandom_range(0, 12)));
                extra = $urandom_range(1, 3 * w_eff);
                stream(extra, harsh);
                settle();
                set_geometry(SIZE_W'(1), SIZE_W'(1));
                stream(1, harsh);
                settle();
                random_sent += n + extra + 1;
            end
        end

        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
